>>> sv/rmse_pkg.sv
// Shared types and constants of the RMSE accumulator.
`default_nettype none

package rmse_pkg;

  // Fixed widths of the payload and of the accumulator.
  localparam int SAMPLE_PORT_W = 16;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 17;
  localparam int MEAN_W        = 32;
  localparam int RMSE_W        = 16;

  // Iteration counts of the shared divide and square-root sequence.
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = RMSE_W;
  localparam int STEP_W     = 6;

  // Controller states.
  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } rmse_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load_div;
    logic div_step;
    logic sqrt_step;
    logic load_out;
  } rmse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tail;
    logic out_full;
  } rmse_status_t;

endpackage : rmse_pkg

`default_nettype wire

>>> sv/rmse_if.sv
// Valid/ready channel interfaces for sample pairs and RMSE results.
`default_nettype none

interface rmse_in_if import rmse_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_PORT_W-1:0] reference_sample;
  logic signed [SAMPLE_PORT_W-1:0] measured_sample;
  logic                            last;

  modport source (output valid, output reference_sample, output measured_sample,
                  output last, input ready);
  modport sink (input valid, input reference_sample, input measured_sample,
                input last, output ready);
endinterface : rmse_in_if

interface rmse_out_if import rmse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RMSE_W-1:0] rmse;
  logic [CNT_W-1:0]  sample_count;
  logic              overflowed;

  modport source (output valid, output rmse, output sample_count, output overflowed,
                  input ready);
  modport sink (input valid, input rmse, input sample_count, input overflowed,
                output ready);
endinterface : rmse_out_if

`default_nettype wire

>>> sv/rmse_ctrl.sv
// Controller state machine that sequences accumulation, divide, root and output.
`default_nettype none

module rmse_ctrl import rmse_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire logic   in_last,
  input  rmse_status_t status,
  output rmse_cmd_t    cmd,
  output rmse_state_t  state
);

  rmse_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              div_end;
  logic              sqrt_end;

  assign div_end  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sqrt_end = (step_r == STEP_W'(SQRT_STEPS - 1));
  assign state    = state_r;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && in_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.tail) begin
          state_nxt = ST_DIV;
          step_nxt  = '0;
        end
      end
      ST_DIV: begin
        if (div_end) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SQRT: begin
        if (sqrt_end) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_full) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_ACCUM: cmd.in_ready  = 1'b1;
      ST_FLUSH: cmd.load_div  = status.tail;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_SQRT:  cmd.sqrt_step = 1'b1;
      ST_DONE:  cmd.load_out  = !status.out_full;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule : rmse_ctrl

`default_nettype wire

>>> sv/rmse_dp.sv
// Datapath: squared-error pipeline, accumulator, serial divider, serial root, output register.
`default_nettype none

module rmse_dp import rmse_pkg::*; #(
  parameter int MAX_SAMPLES  = 65536,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [SAMPLE_PORT_W-1:0] in_reference_sample,
  input  wire logic [SAMPLE_PORT_W-1:0] in_measured_sample,
  input  wire logic                     in_last,
  input  rmse_cmd_t                     cmd,
  output rmse_status_t                  status,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [RMSE_W-1:0]             out_rmse,
  output logic [CNT_W-1:0]              out_sample_count,
  output logic                          out_overflowed
);

  localparam int                SW      = SAMPLE_WIDTH;
  localparam int                SQ_W    = 2 * SW;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_SAMPLES);

  logic                    accept;
  logic                    full;
  logic signed [SW:0]      diff;
  logic [SW:0]             diff_abs;

  logic [CNT_W-1:0]        count_r;
  logic                    ovf_r;
  logic                    v1_r, last1_r;
  logic [SW-1:0]           mag1_r;
  logic                    v2_r, last2_r;
  logic [SQ_W-1:0]         sq2_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_total;

  logic [SUM_W-1:0]        quo_r;
  logic [CNT_W-1:0]        rem_r;
  logic [CNT_W-1:0]        div_r;
  logic                    ovf_hold_r;
  logic [CNT_W:0]          div_trial;
  logic [CNT_W:0]          div_diff;
  logic                    div_ge;

  logic [RMSE_W-1:0]       root_r;
  logic [RMSE_W+1:0]       srem_r;
  logic [RMSE_W+3:0]       sq_trial;
  logic [RMSE_W+3:0]       sq_test;
  logic [RMSE_W+3:0]       sq_diff;
  logic                    sq_ge;

  logic                    out_valid_r;
  logic [RMSE_W-1:0]       out_rmse_r;
  logic [CNT_W-1:0]        out_cnt_r;
  logic                    out_ovf_r;

  assign accept = in_valid && cmd.in_ready;
  assign full   = (count_r == MAX_CNT);

  // Difference of the sign-extended low sample bits and its magnitude.
  assign diff     = $signed({in_reference_sample[SW-1], in_reference_sample[SW-1:0]})
                  - $signed({in_measured_sample[SW-1], in_measured_sample[SW-1:0]});
  assign diff_abs = diff[SW] ? (SW+1)'(-diff) : diff;

  // Pair count and overflow flag follow each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_div) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Stage one holds the magnitude, stage two the square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      v2_r    <= 1'b0;
      last2_r <= 1'b0;
    end else begin
      v1_r    <= accept && !full;
      last1_r <= accept && in_last;
      v2_r    <= v1_r;
      last2_r <= last1_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r <= diff_abs[SW-1:0];
    sq2_r  <= mag1_r * mag1_r;
  end

  assign sum_total = sum_r + (v2_r ? SUM_W'(sq2_r) : SUM_W'(0));

  // Accumulator; the final sum moves into the divider once the last pair leaves the
  // square pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.load_div) begin
      sum_r <= '0;
    end else if (v2_r) begin
      sum_r <= sum_total;
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  assign div_trial = {rem_r, quo_r[SUM_W-1]};
  assign div_diff  = div_trial - {1'b0, div_r};
  assign div_ge    = (div_trial >= {1'b0, div_r});

  // Root step: two radicand bits per cycle, from the top of the low MEAN_W quotient bits.
  assign sq_trial = {srem_r, quo_r[MEAN_W-1 -: 2]};
  assign sq_test  = {2'b00, root_r, 2'b01};
  assign sq_diff  = sq_trial - sq_test;
  assign sq_ge    = (sq_trial >= sq_test);

  // Shared quotient/radicand register and the divider and root state.
  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quo_r      <= sum_total;
      rem_r      <= '0;
      div_r      <= count_r;
      ovf_hold_r <= ovf_r;
      root_r     <= '0;
      srem_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? sq_diff[RMSE_W+1:0] : sq_trial[RMSE_W+1:0];
      root_r <= {root_r[RMSE_W-2:0], sq_ge};
      quo_r  <= {quo_r[SUM_W-3:0], 2'b00};
    end
  end

  // Output register; a finished result waits here until its transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rmse_r <= root_r;
      out_cnt_r  <= div_r;
      out_ovf_r  <= ovf_hold_r;
    end
  end

  assign status.tail     = last2_r;
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_rmse         = out_rmse_r;
  assign out_sample_count = out_cnt_r;
  assign out_overflowed   = out_ovf_r;

endmodule : rmse_dp

`default_nettype wire

>>> sv/rmse_accumulator_core.sv
// Top level of the RMSE accumulator: controller, datapath and channel wiring.
`default_nettype none

// Takes signed Q7.8 sample pairs at one transaction per cycle, accumulates the
// squared differences and, on the pair marked last, returns floor(sqrt(sum / count))
// in unsigned Q8.8 with the pair count and an overflow flag. Pairs beyond
// MAX_SAMPLES are dropped and flagged. After a last pair the input stalls while
// the square pipeline drains, a bit-serial divider and then a bit-serial square
// root run, and the done state loads the output register. If the previous
// result has not been taken by then, the block waits for it before accepting
// the next run.

module rmse_accumulator_core import rmse_pkg::*; #(
  parameter int MAX_SAMPLES  = 65536,
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rmse_in_if.sink   in_chan,
  rmse_out_if.source out_chan
);

  rmse_cmd_t    cmd;
  rmse_status_t status;
  rmse_state_t  state;

  assign in_chan.ready = cmd.in_ready;

  // Sequencing of a run.
  rmse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  // Arithmetic and result storage.
  rmse_dp #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_chan.valid),
    .in_reference_sample (in_chan.reference_sample),
    .in_measured_sample  (in_chan.measured_sample),
    .in_last             (in_chan.last),
    .cmd                 (cmd),
    .status              (status),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_rmse            (out_chan.rmse),
    .out_sample_count    (out_chan.sample_count),
    .out_overflowed      (out_chan.overflowed)
  );

  // A result only appears after the root has been loaded from the done state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(state == ST_DONE))
    else $error("result valid rose outside the done state");

  // The input stalls right after the last pair of a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.last) |=> !in_chan.ready)
    else $error("input still ready after last pair");

  // The output register is never overwritten while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_chan.valid && !out_chan.ready))
    else $error("pending result overwritten");

  // The divider is only started while the input is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_div |-> (state == ST_FLUSH) && !in_chan.ready)
    else $error("divider started outside flush");

endmodule : rmse_accumulator_core

`default_nettype wire
